// ===== hw/rtl/podr_pkg.sv =====
// Shared types, constants and helper functions for the point rotator pipeline.
package podr_pkg;

    localparam int COORD_W  = 24;            // Q7.16 coordinate
    localparam int WIDE_W   = 26;            // unsaturated intermediate coordinate
    localparam int SPEED_W  = 18;
    localparam int TIME_W   = 24;
    localparam int TILT_W   = 19;
    localparam int CX_W     = 33;            // CORDIC x/y, Q1.30 with headroom
    localparam int ANG_W    = 34;            // signed angle, Q.30 radians
    localparam int MAG_W    = 40;            // angle magnitude before reduction
    localparam int PROD_W   = 43;            // speed times time, Q.32
    localparam int MUL_W    = 59;            // coordinate times sine or cosine
    localparam int TABLE_LEN = 24;

    localparam logic [MAG_W-1:0] TWO_PI  = MAG_W'(64'd6746518852);
    localparam logic [MAG_W-1:0] ANG_PI  = MAG_W'(64'd3373259426);
    localparam logic signed [ANG_W-1:0] PI_S   = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] HALF_S = ANG_W'(64'sd1686629713);
    localparam logic signed [CX_W-1:0]  GAIN   = CX_W'(64'sd652032874);
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef enum logic {
        OP_ORBIT = 1'b0,
        OP_DRAG  = 1'b1
    } op_t;

    // point carried along the pipeline
    typedef struct packed {
        op_t                       op;
        logic signed [WIDE_W-1:0]  x;
        logic signed [WIDE_W-1:0]  y;
        logic signed [WIDE_W-1:0]  z;
    } pnt_t;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
        logic                    skip;
    } lane_t;

    typedef struct packed {
        lane_t l0;
        lane_t l1;
    } lane_pair_t;

    // cosine and sine of one rotation
    typedef struct packed {
        logic signed [CX_W-1:0] c;
        logic signed [CX_W-1:0] s;
        logic                   skip;
    } trig_t;

    typedef struct packed {
        trig_t r0;   // first rotation (orbit about z, or drag about y)
        trig_t r1;   // second rotation (drag about x)
    } rot_pair_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = ANG_W'(64'sd843314857);
            5'd1:  v = ANG_W'(64'sd497837829);
            5'd2:  v = ANG_W'(64'sd263043837);
            5'd3:  v = ANG_W'(64'sd133525159);
            5'd4:  v = ANG_W'(64'sd67021687);
            5'd5:  v = ANG_W'(64'sd33543516);
            5'd6:  v = ANG_W'(64'sd16775851);
            5'd7:  v = ANG_W'(64'sd8388437);
            5'd8:  v = ANG_W'(64'sd4194283);
            5'd9:  v = ANG_W'(64'sd2097149);
            5'd10: v = ANG_W'(64'sd1048576);
            5'd11: v = ANG_W'(64'sd524288);
            5'd12: v = ANG_W'(64'sd262144);
            5'd13: v = ANG_W'(64'sd131072);
            5'd14: v = ANG_W'(64'sd65536);
            5'd15: v = ANG_W'(64'sd32768);
            5'd16: v = ANG_W'(64'sd16384);
            5'd17: v = ANG_W'(64'sd8192);
            5'd18: v = ANG_W'(64'sd4096);
            5'd19: v = ANG_W'(64'sd2048);
            5'd20: v = ANG_W'(64'sd1024);
            5'd21: v = ANG_W'(64'sd512);
            5'd22: v = ANG_W'(64'sd256);
            5'd23: v = ANG_W'(64'sd128);
            default: v = '0;
        endcase
        return v;
    endfunction

    // one micro-rotation with floor shifts
    function automatic lane_t cordic_step(input lane_t l, input logic [4:0] i);
        lane_t r;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        r  = l;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (!l.z[ANG_W-1]) begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atan_q30(i);
        end else begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atan_q30(i);
        end
        return r;
    endfunction

    // subtract one scaled multiple of two pi when it fits
    function automatic logic [MAG_W-1:0] mod_step(input logic [MAG_W-1:0] r,
                                                  input logic [2:0] k);
        logic [MAG_W-1:0] m;
        m = TWO_PI << k;
        return (r >= m) ? r - m : r;
    endfunction

endpackage

// ===== hw/rtl/podr_angle.sv =====
// Angle front end: orbit product, reduction modulo two pi, quadrant fold.
module podr_angle (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  podr_pkg::pnt_t                       in_pnt,
    input  logic signed [podr_pkg::SPEED_W-1:0]  in_speed,
    input  logic [podr_pkg::TIME_W-1:0]          in_time,
    input  logic signed [podr_pkg::TILT_W-1:0]   in_tilt_x,
    input  logic signed [podr_pkg::TILT_W-1:0]   in_tilt_y,
    output logic                                 out_valid,
    output podr_pkg::pnt_t                       out_pnt,
    output podr_pkg::lane_pair_t                 out_lanes
);

    localparam int NST = 7;

    logic [NST-1:0] v_reg;
    podr_pkg::pnt_t p_reg [NST];

    // stage 1: product and raw tilts
    logic signed [podr_pkg::PROD_W-1:0] prod_reg;
    logic signed [podr_pkg::TILT_W-1:0] tx_reg, ty_reg;
    logic signed [podr_pkg::PROD_W-1:0] prod_next;

    // stage 2..5: magnitudes and signs
    logic [podr_pkg::MAG_W-1:0] m0_reg [2:5];
    logic [podr_pkg::MAG_W-1:0] m1_reg [2:5];
    logic                       n0_reg [2:5];
    logic                       n1_reg [2:5];

    // stage 6: wrapped angles
    logic signed [podr_pkg::ANG_W-1:0] w0_reg, w1_reg;
    logic                              k0_reg, k1_reg;

    // stage 7: lanes
    podr_pkg::lane_pair_t lanes_reg;

    logic signed [podr_pkg::PROD_W-1:0] a0_next, a1_next;
    logic [podr_pkg::MAG_W-1:0] r0_a, r0_b, r1_a, r1_b, r0_c, r1_c;
    logic signed [podr_pkg::ANG_W-1:0] w0_next, w1_next;
    podr_pkg::lane_pair_t lanes_next;

    function automatic logic signed [podr_pkg::ANG_W-1:0] wrap(
        input logic [podr_pkg::MAG_W-1:0] r, input logic neg);
        logic signed [podr_pkg::ANG_W-1:0] w;
        w = $signed(podr_pkg::ANG_W'(r));
        if (r > podr_pkg::ANG_PI) begin
            w = $signed(podr_pkg::ANG_W'(r)) - $signed(podr_pkg::ANG_W'(podr_pkg::TWO_PI));
        end
        return neg ? -w : w;
    endfunction

    function automatic podr_pkg::lane_t fold(input logic signed [podr_pkg::ANG_W-1:0] w,
                                             input logic skip);
        podr_pkg::lane_t l;
        l.x    = podr_pkg::GAIN;
        l.y    = '0;
        l.z    = w;
        l.flip = 1'b0;
        l.skip = skip;
        if (w > podr_pkg::HALF_S) begin
            l.z    = w - podr_pkg::PI_S;
            l.flip = 1'b1;
        end else if (w < -podr_pkg::HALF_S) begin
            l.z    = w + podr_pkg::PI_S;
            l.flip = 1'b1;
        end
        return l;
    endfunction

    // form the product and the two angles, then reduce, wrap and fold them
    always_comb begin
        prod_next = podr_pkg::PROD_W'(in_speed) * $signed({19'd0, in_time});
        if (p_reg[0].op == podr_pkg::OP_DRAG) begin
            a0_next = podr_pkg::PROD_W'($signed({ty_reg, 14'd0}));
        end else begin
            a0_next = (prod_reg + podr_pkg::PROD_W'(2)) >>> 2;
        end
        a1_next = podr_pkg::PROD_W'($signed({tx_reg, 14'd0}));
        // largest orbit magnitude needs the 64 * two pi step as well
        r0_a = podr_pkg::mod_step(podr_pkg::mod_step(podr_pkg::mod_step(m0_reg[2], 3'd6),
                                                     3'd5), 3'd4);
        r1_a = podr_pkg::mod_step(podr_pkg::mod_step(podr_pkg::mod_step(m1_reg[2], 3'd6),
                                                     3'd5), 3'd4);
        r0_b = podr_pkg::mod_step(podr_pkg::mod_step(m0_reg[3], 3'd3), 3'd2);
        r1_b = podr_pkg::mod_step(podr_pkg::mod_step(m1_reg[3], 3'd3), 3'd2);
        r0_c = podr_pkg::mod_step(podr_pkg::mod_step(m0_reg[4], 3'd1), 3'd0);
        r1_c = podr_pkg::mod_step(podr_pkg::mod_step(m1_reg[4], 3'd1), 3'd0);
        w0_next = wrap(m0_reg[5], n0_reg[5]);
        w1_next = wrap(m1_reg[5], n1_reg[5]);
        lanes_next.l0 = fold(w0_reg, k0_reg);
        lanes_next.l1 = fold(w1_reg, k1_reg);
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= in_pnt;
            for (int i = 1; i < NST; i++) begin
                p_reg[i] <= p_reg[i-1];
            end
            prod_reg  <= prod_next;
            tx_reg    <= in_tilt_x;
            ty_reg    <= in_tilt_y;
            n0_reg[2] <= a0_next[podr_pkg::PROD_W-1];
            n1_reg[2] <= a1_next[podr_pkg::PROD_W-1];
            m0_reg[2] <= podr_pkg::MAG_W'(a0_next[podr_pkg::PROD_W-1] ? -a0_next : a0_next);
            m1_reg[2] <= podr_pkg::MAG_W'(a1_next[podr_pkg::PROD_W-1] ? -a1_next : a1_next);
            m0_reg[3] <= r0_a;
            m1_reg[3] <= r1_a;
            m0_reg[4] <= r0_b;
            m1_reg[4] <= r1_b;
            m0_reg[5] <= r0_c;
            m1_reg[5] <= r1_c;
            n0_reg[3] <= n0_reg[2];
            n1_reg[3] <= n1_reg[2];
            n0_reg[4] <= n0_reg[3];
            n1_reg[4] <= n1_reg[3];
            n0_reg[5] <= n0_reg[4];
            n1_reg[5] <= n1_reg[4];
            w0_reg    <= w0_next;
            w1_reg    <= w1_next;
            k0_reg    <= (m0_reg[5] == '0);
            k1_reg    <= (m1_reg[5] == '0);
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_pnt   = p_reg[NST-1];
    assign out_lanes = lanes_reg;

endmodule

// ===== hw/rtl/podr_cordic.sv =====
// Two-lane pipelined CORDIC, one micro-rotation per stage, then sign fold.
module podr_cordic #(
    parameter int STAGES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  podr_pkg::pnt_t        in_pnt,
    input  podr_pkg::lane_pair_t  in_lanes,
    output logic                  out_valid,
    output podr_pkg::pnt_t        out_pnt,
    output podr_pkg::rot_pair_t   out_rot
);

    logic [STAGES-1:0]    v_reg;
    podr_pkg::pnt_t       p_reg [STAGES];
    podr_pkg::lane_pair_t l_reg [STAGES];

    logic                 vo_reg;
    podr_pkg::pnt_t       po_reg;
    podr_pkg::rot_pair_t  rot_reg;
    podr_pkg::rot_pair_t  rot_next;

    // micro-rotation stages
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        podr_pkg::lane_pair_t src;
        logic                 src_v;
        if (g == 0) begin : g_first
            assign src   = in_lanes;
            assign src_v = in_valid;
            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[g] <= in_pnt;
                end
            end
        end else begin : g_rest
            assign src   = l_reg[g-1];
            assign src_v = v_reg[g-1];
            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[g] <= p_reg[g-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                l_reg[g].l0 <= podr_pkg::cordic_step(src.l0, 5'(g));
                l_reg[g].l1 <= podr_pkg::cordic_step(src.l1, 5'(g));
            end
        end
    end

    // negate when the angle was folded by pi
    always_comb begin
        rot_next.r0.c    = l_reg[STAGES-1].l0.flip ? -l_reg[STAGES-1].l0.x : l_reg[STAGES-1].l0.x;
        rot_next.r0.s    = l_reg[STAGES-1].l0.flip ? -l_reg[STAGES-1].l0.y : l_reg[STAGES-1].l0.y;
        rot_next.r0.skip = l_reg[STAGES-1].l0.skip;
        rot_next.r1.c    = l_reg[STAGES-1].l1.flip ? -l_reg[STAGES-1].l1.x : l_reg[STAGES-1].l1.x;
        rot_next.r1.s    = l_reg[STAGES-1].l1.flip ? -l_reg[STAGES-1].l1.y : l_reg[STAGES-1].l1.y;
        rot_next.r1.skip = l_reg[STAGES-1].l1.skip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            po_reg  <= p_reg[STAGES-1];
            rot_reg <= rot_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_pnt   = po_reg;
    assign out_rot   = rot_reg;

endmodule

// ===== hw/rtl/podr_turn.sv =====
// Plane rotation of one coordinate pair: multiply stage, then sum and round.
module podr_turn #(
    parameter bit FIRST = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  podr_pkg::pnt_t       in_pnt,
    input  podr_pkg::rot_pair_t  in_rot,
    output logic                 out_valid,
    output podr_pkg::pnt_t       out_pnt,
    output podr_pkg::rot_pair_t  out_rot
);

    localparam logic signed [podr_pkg::MUL_W:0] HALF_LSB = (podr_pkg::MUL_W+1)'(64'sd536870912);

    logic                v1_reg, v2_reg;
    podr_pkg::pnt_t      p1_reg, p2_reg;
    podr_pkg::rot_pair_t r1_reg, r2_reg;
    logic                skip_reg;
    logic signed [podr_pkg::MUL_W-1:0] ac_reg, bs_reg, as_reg, bc_reg;

    podr_pkg::trig_t                    t;
    logic signed [podr_pkg::WIDE_W-1:0] a, b, na, nb;
    logic                               skip;
    logic signed [podr_pkg::MUL_W:0]    sa, sb;
    podr_pkg::pnt_t                     p_next;

    // pick the pair and the rotation
    always_comb begin
        t = FIRST ? in_rot.r0 : in_rot.r1;
        if (FIRST) begin
            a = in_pnt.x;
            b = (in_pnt.op == podr_pkg::OP_DRAG) ? in_pnt.z : in_pnt.y;
            skip = t.skip;
        end else begin
            a = in_pnt.y;
            b = in_pnt.z;
            skip = t.skip || (in_pnt.op != podr_pkg::OP_DRAG);
        end
    end

    // sum, round half up to Q.16 and write back
    always_comb begin
        sa = (podr_pkg::MUL_W+1)'(ac_reg) - (podr_pkg::MUL_W+1)'(bs_reg) + HALF_LSB;
        sb = (podr_pkg::MUL_W+1)'(as_reg) + (podr_pkg::MUL_W+1)'(bc_reg) + HALF_LSB;
        na = podr_pkg::WIDE_W'(sa >>> 30);
        nb = podr_pkg::WIDE_W'(sb >>> 30);
        p_next = p1_reg;
        if (!skip_reg) begin
            if (FIRST) begin
                p_next.x = na;
                if (p1_reg.op == podr_pkg::OP_DRAG) begin
                    p_next.z = nb;
                end else begin
                    p_next.y = nb;
                end
            end else begin
                p_next.y = na;
                p_next.z = nb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // hold products one stage, then the rotated point
    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg   <= podr_pkg::MUL_W'(a) * podr_pkg::MUL_W'(t.c);
            bs_reg   <= podr_pkg::MUL_W'(b) * podr_pkg::MUL_W'(t.s);
            as_reg   <= podr_pkg::MUL_W'(a) * podr_pkg::MUL_W'(t.s);
            bc_reg   <= podr_pkg::MUL_W'(b) * podr_pkg::MUL_W'(t.c);
            skip_reg <= skip;
            p1_reg   <= in_pnt;
            r1_reg   <= in_rot;
            p2_reg   <= p_next;
            r2_reg   <= r1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_pnt   = p2_reg;
    assign out_rot   = r2_reg;

endmodule

// ===== hw/rtl/point_orbit_and_drag_rotator_unit.sv =====
// Point rotator top level: stream ports, pipeline chain and saturating output register.
// Rotates one 3D point per transaction: orbit (operation 0) turns it about z by
// orbit_speed * time_step; drag (operation 1) turns it about y by tilt_y, then about x
// by tilt_x. Fully pipelined, one transaction per cycle while the output is not held.
// The chain is seven angle-reduction stages, one CORDIC stage per rotation step plus a
// sign stage, two stages per plane rotation and one output register. The whole pipeline
// holds while a result waits on m_tready, so s_tready follows that output register.
module point_orbit_and_drag_rotator_unit #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // point_x, point_y, point_z, orbit_speed, time_step, tilt_x, tilt_y
    input  logic [151:0]  s_tdata,
    // operation
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [71:0]   m_tdata
);

    logic en;
    podr_pkg::pnt_t in_pnt;

    logic                 a_valid, c_valid, t1_valid, t2_valid;
    podr_pkg::pnt_t       a_pnt, c_pnt, t1_pnt, t2_pnt;
    podr_pkg::lane_pair_t a_lanes;
    podr_pkg::rot_pair_t  c_rot, t1_rot;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    function automatic logic [podr_pkg::COORD_W-1:0] sat(
        input logic signed [podr_pkg::WIDE_W-1:0] v);
        if (v > podr_pkg::WIDE_W'(podr_pkg::COORD_MAX)) begin
            return podr_pkg::COORD_MAX;
        end else if (v < podr_pkg::WIDE_W'(podr_pkg::COORD_MIN)) begin
            return podr_pkg::COORD_MIN;
        end
        return podr_pkg::COORD_W'(v);
    endfunction

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // unpack the input transaction
    always_comb begin
        in_pnt.op = podr_pkg::op_t'(s_tuser);
        in_pnt.x  = podr_pkg::WIDE_W'($signed(s_tdata[23:0]));
        in_pnt.y  = podr_pkg::WIDE_W'($signed(s_tdata[47:24]));
        in_pnt.z  = podr_pkg::WIDE_W'($signed(s_tdata[71:48]));
    end

    podr_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pnt    (in_pnt),
        .in_speed  ($signed(s_tdata[89:72])),
        .in_time   (s_tdata[113:90]),
        .in_tilt_x ($signed(s_tdata[132:114])),
        .in_tilt_y ($signed(s_tdata[151:133])),
        .out_valid (a_valid),
        .out_pnt   (a_pnt),
        .out_lanes (a_lanes)
    );

    podr_cordic #(
        .STAGES (ROTATION_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid),
        .in_pnt    (a_pnt),
        .in_lanes  (a_lanes),
        .out_valid (c_valid),
        .out_pnt   (c_pnt),
        .out_rot   (c_rot)
    );

    podr_turn #(
        .FIRST (1'b1)
    ) u_turn_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid),
        .in_pnt    (c_pnt),
        .in_rot    (c_rot),
        .out_valid (t1_valid),
        .out_pnt   (t1_pnt),
        .out_rot   (t1_rot)
    );

    podr_turn #(
        .FIRST (1'b0)
    ) u_turn_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t1_valid),
        .in_pnt    (t1_pnt),
        .in_rot    (t1_rot),
        .out_valid (t2_valid),
        .out_pnt   (t2_pnt),
        .out_rot   ()
    );

    // saturate into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= t2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sat(t2_pnt.z), sat(t2_pnt.y), sat(t2_pnt.x)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a finished point reaches the output register
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        en && t2_valid |=> m_tvalid_reg)
        else $error("finished point not loaded into output register");

    // a held output freezes the last rotation stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(t2_valid) && $stable(t2_pnt))
        else $error("pipeline moved while output was held");

    // orbit transactions leave z untouched through the second rotation
    a_orbit_z: assert property (@(posedge aclk) disable iff (!aresetn)
        en && t1_valid && t1_pnt.op == podr_pkg::OP_ORBIT ##1 en
        |=> t2_pnt.z == $past(t1_pnt.z, 2))
        else $error("orbit point changed in z");

endmodule

// ===== sim/point_orbit_and_drag_rotator_unit_tb.sv =====
// Self-checking testbench for the 3D point orbit and drag rotator stream unit.
`timescale 1ns / 100ps

module point_orbit_and_drag_rotator_unit_tb;

    localparam int    WATCHDOG_LIMIT = 20000;
    localparam int    DRAIN_CYCLES   = 64;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    NUM_STAGES     = 16;
    localparam int    PRED_DEPTH     = 1024;
    localparam longint GAIN_Q30      = 64'sd652032874;
    localparam longint A_PI          = 64'sd3373259426;
    localparam longint A_TWO_PI      = 64'sd6746518852;
    localparam longint A_HALF_PI     = 64'sd1686629713;
    localparam int    TILT_LIM       = 205887;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } point_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [151:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [71:0]   m_tdata;

    point_t  pred_mem[PRED_DEPTH];
    int      pred_wr;
    int      pred_rd;
    int      mismatches;
    int      sent_count;
    int      recv_count;
    int      orbit_count;
    int      drag_count;
    int      idle_cycles;
    bit      idle_on;
    int      hold_req;
    int      hold_seen;
    int      hold_left;
    int      stall_left;
    int      atan_tab[24];

    point_orbit_and_drag_rotator_unit #(.ROTATION_STAGES(NUM_STAGES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                     262144, 131072, 65536, 32768, 16384, 8192,
                     4096, 2048, 1024, 512, 256, 128};
    end

    // reduce an angle into [-pi, pi]
    function automatic longint wrap_angle(input longint a);
        longint w;
        w = a % A_TWO_PI;
        if (w > A_PI)
            w = w - A_TWO_PI;
        else if (w < -A_PI)
            w = w + A_TWO_PI;
        return w;
    endfunction

    // rotate the pair (a, b) by ang in Q.30, keeping Q.16 unsaturated
    function automatic void plane_turn(input longint ang, inout longint a, inout longint b);
        longint cx, cy, cz, dx, dy, na, nb;
        bit     flip;
        if (ang == 0)
            return;
        flip = 1'b0;
        cx = GAIN_Q30;
        cy = 0;
        cz = ang;
        if (cz > A_HALF_PI) begin
            cz = cz - A_PI;
            flip = 1'b1;
        end else if (cz < -A_HALF_PI) begin
            cz = cz + A_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < NUM_STAGES && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - atan_tab[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + atan_tab[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        na = (a * cx - b * cy + (64'sd1 <<< 29)) >>> 30;
        nb = (a * cy + b * cx + (64'sd1 <<< 29)) >>> 30;
        a = na;
        b = nb;
    endfunction

    function automatic logic signed [23:0] clamp_coord(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    // compute the rotated point for one input transaction
    function automatic point_t rotate_point(input podr_pkg::op_t op, input logic [151:0] d);
        longint x, y, z, prod, ang, ax, ay;
        point_t r;
        x = longint'($signed(d[23:0]));
        y = longint'($signed(d[47:24]));
        z = longint'($signed(d[71:48]));
        if (op == podr_pkg::OP_ORBIT) begin
            prod = longint'($signed(d[89:72])) * longint'({40'd0, d[113:90]});
            ang = ((prod + (64'sd1 <<< 42) + 2) >>> 2) - (64'sd1 <<< 40);
            plane_turn(wrap_angle(ang), x, y);
        end else begin
            ax = wrap_angle(longint'($signed(d[132:114])) * 16384);
            ay = wrap_angle(longint'($signed(d[151:133])) * 16384);
            plane_turn(ay, x, z);
            plane_turn(ax, y, z);
        end
        r.x = clamp_coord(x);
        r.y = clamp_coord(y);
        r.z = clamp_coord(z);
        return r;
    endfunction

    // offer one point and hold it until the transaction completes
    task automatic send_point(input podr_pkg::op_t op, input logic signed [23:0] px,
                              input logic signed [23:0] py, input logic signed [23:0] pz,
                              input logic signed [17:0] spd, input logic [23:0] tstep,
                              input logic signed [18:0] tx, input logic signed [18:0] ty);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ty, tx, tstep, spd, pz, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == podr_pkg::OP_ORBIT)
            orbit_count++;
        else
            drag_count++;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(int'($urandom_range(0, 131072)) - 65536);
            3: return 24'sd0;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random(input bit allow_any);
        podr_pkg::op_t   op;
        logic [17:0]     spd;
        logic [23:0]     tstep;
        logic [18:0]     tx, ty;
        op    = podr_pkg::op_t'($urandom_range(0, 1));
        spd   = ($urandom_range(0, 9) == 0) ? 18'd0 : 18'(int'($urandom_range(0, 131072)) - 65536);
        tstep = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom);
        if ($urandom_range(0, 3) == 0)
            tstep = 24'($urandom_range(0, 255));
        tx = ($urandom_range(0, 7) == 0) ? 19'd0
           : 19'(int'($urandom_range(0, 2 * TILT_LIM)) - TILT_LIM);
        ty = ($urandom_range(0, 7) == 0) ? 19'd0
           : 19'(int'($urandom_range(0, 2 * TILT_LIM)) - TILT_LIM);
        if (allow_any && $urandom_range(0, 9) == 0) begin
            spd = 18'($urandom);
            tx  = 19'($urandom);
            ty  = 19'($urandom);
        end
        send_point(op, rand_coord(), rand_coord(), rand_coord(), spd, tstep, tx, ty);
    endtask

    // receiver readiness: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // record accepted points, check each result against the oldest prediction
    always @(posedge aclk) begin
        point_t exp_pt;
        point_t got_pt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred_mem[pred_wr % PRED_DEPTH] = rotate_point(podr_pkg::op_t'(s_tuser),
                                                              s_tdata);
                pred_wr++;
                sent_count++;
            end
            if (m_tvalid && m_tready) begin
                recv_count++;
                got_pt.x = m_tdata[23:0];
                got_pt.y = m_tdata[47:24];
                got_pt.z = m_tdata[71:48];
                if (pred_wr == pred_rd) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%0d y=%0d z=%0d",
                                 got_pt.x, got_pt.y, got_pt.z);
                end else begin
                    exp_pt = pred_mem[pred_rd % PRED_DEPTH];
                    pred_rd++;
                    if (got_pt.x !== exp_pt.x || got_pt.y !== exp_pt.y ||
                        got_pt.z !== exp_pt.z) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                     recv_count, exp_pt.x, exp_pt.y, exp_pt.z,
                                     got_pt.x, got_pt.y, got_pt.z);
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pred_wr - pred_rd);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apply_reset();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // extremes, both operations and the named special cases
    task automatic test_directed();
        // orbit with zero speed, zero time and a point at the origin
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, -24'sd131072, 24'sd3, 18'sd0, 24'hFFFFFF,
                   19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, 24'sd65536, 24'sd7, 18'sd65536, 24'd0,
                   19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sd0, 24'sd0, 24'sd0, 18'sd40000, 24'd70000,
                   19'sd0, 19'sd0);
        // orbit at the field extremes
        send_point(podr_pkg::OP_ORBIT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 18'sd65536,
                   24'hFFFFFF, -19'sd1, -19'sd1);
        send_point(podr_pkg::OP_ORBIT, 24'sh800000, 24'sh800000, 24'sh7FFFFF, -18'sd65536,
                   24'hFFFFFF, 19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sh7FFFFF, 24'sh800000, 24'sd0, 18'sd1, 24'd1,
                   19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, 24'sd0, 24'sd0, 18'sd51472, 24'd262144,
                   19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, 24'sd0, 24'sd0, -18'sd65536, 24'd205887,
                   19'sd0, 19'sd0);
        // orbit speed beyond the usual range, largest product of both signs
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, 24'sd32768, 24'sd5, 18'sh20000,
                   24'hFFFFFF, 19'sd0, 19'sd0);
        send_point(podr_pkg::OP_ORBIT, 24'sd65536, -24'sd32768, 24'sd5, 18'sh1FFFF,
                   24'hFFFFFF, 19'sd0, 19'sd0);
        // drag with zero tilts, origin, tilts at and beyond pi
        send_point(podr_pkg::OP_DRAG, 24'sd12345, -24'sd54321, 24'sd999, 18'sd65536,
                   24'hFFFFFF, 19'sd0, 19'sd0);
        send_point(podr_pkg::OP_DRAG, 24'sd0, 24'sd0, 24'sd0, 18'sd0, 24'd0, 19'sd100000,
                   -19'sd50000);
        send_point(podr_pkg::OP_DRAG, 24'sd65536, 24'sd65536, 24'sd65536, 18'sd0, 24'd0,
                   19'sd205887, -19'sd205887);
        send_point(podr_pkg::OP_DRAG, 24'sd65536, -24'sd65536, 24'sd65536, 18'sd0, 24'd0,
                   19'sh3FFFF, 19'sh40000);
        send_point(podr_pkg::OP_DRAG, 24'sd65536, 24'sd0, 24'sd0, 18'sd0, 24'd0, 19'sd102944,
                   19'sd102944);
        send_point(podr_pkg::OP_DRAG, 24'sd65536, 24'sd4096, 24'sd0, 18'sd0, 24'd0,
                   -19'sd102944, -19'sd30000);
        // drag intermediate beyond the output range, then saturation
        send_point(podr_pkg::OP_DRAG, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 18'sd0, 24'd0,
                   19'sd51472, 19'sd51472);
        send_point(podr_pkg::OP_DRAG, 24'sh800000, 24'sh800000, 24'sh800000, 18'sd0, 24'd0,
                   -19'sd51472, 19'sd51472);
        send_point(podr_pkg::OP_DRAG, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 18'sd0, 24'd0,
                   19'sd0, 19'sd51472);
        send_point(podr_pkg::OP_DRAG, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 18'sd0, 24'd0,
                   19'sd51472, 19'sd0);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_random(1'b1);
    endtask

    // hold the receiver off while the sender keeps offering points
    task automatic test_backpressure();
        bit saved;
        saved = idle_on;
        idle_on = 1'b0;
        @(negedge aclk);
        hold_req = hold_req + 1;
        for (int n = 0; n < 80; n++)
            send_random(1'b0);
        idle_on = saved;
    endtask

    task automatic finish_run();
        int waited;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pred_wr != pred_rd) @(posedge aclk);
        waited = 0;
        while (waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        $display("covered %0d orbit and %0d drag points, %0d results checked",
                 orbit_count, drag_count, recv_count);
        $display("with random stalls on both sides and one long receiver hold-off");
        if (mismatches == 0 && sent_count == recv_count) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    endtask

    initial begin
        mismatches  = 0;
        sent_count  = 0;
        recv_count  = 0;
        orbit_count = 0;
        drag_count  = 0;
        idle_cycles = 0;
        pred_wr     = 0;
        pred_rd     = 0;
        hold_req    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        stall_left  = 0;
        idle_on     = 1'b1;
        m_tready    = 1'b0;
        apply_reset();
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(180);
        idle_on = 1'b0;
        test_random(90);
        finish_run();
    end

endmodule
